>>> hw/rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge, off while reset is low
`define ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

// implication checked at every rising clock edge, off while reset is low
`define ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked at every rising clock edge, off while reset is low
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hw/rtl/lts_pkg.sv
// types and constants of the lottery task scheduler
package lts_pkg;

    localparam int SUM_W = 40;
    localparam logic [SUM_W-1:0] SUM_LIMIT = 40'h000FFFFFFF;

    typedef enum logic [1:0] {
        ST_FINISHED = 2'd0,
        ST_READY    = 2'd1,
        ST_RUNNING  = 2'd2
    } task_state_t;

    typedef enum logic [1:0] {
        MODE_LOAD     = 2'd0,
        MODE_SELECT   = 2'd1,
        MODE_DISPATCH = 2'd2,
        MODE_FINISH   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_EMPTY   = 2'd1,
        STATUS_ILLEGAL = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_DIVIDE,
        FSM_PICK,
        FSM_EMIT
    } fsm_t;

    // data handed from cell to cell along the chain
    typedef struct packed {
        logic             valid;
        logic             pick;      // 0 sum pass, 1 winner pass
        logic [SUM_W-1:0] sum;       // ready ticket sum, or running sum in pick pass
        logic             running;
        task_state_t      tgt_state;
        logic [31:0]      tgt_disp;
        logic             found;
        logic [7:0]       winner;
    } link_t;

    // values held steady by the controller during a pass
    typedef struct packed {
        logic [4:0]  n;
        logic [3:0]  idx;
        logic [27:0] drawn;
    } ctx_t;

    // table update broadcast to all cells
    typedef struct packed {
        logic        en;
        mode_t       op;
        logic [3:0]  idx;
        logic [23:0] ticket;
        logic        to_fin;
    } wr_cmd_t;

endpackage

>>> hw/rtl/lts_cell.sv
// one task entry of the scheduler chain
module lts_cell #(
    parameter int CELL_ID     = 0,
    parameter int TICKET_BITS = 24
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  lts_pkg::ctx_t    ctx,
    input  lts_pkg::wr_cmd_t wr_cmd,
    input  lts_pkg::link_t   link_in,
    output lts_pkg::link_t   link_out
);

    lts_pkg::task_state_t    state_reg, state_next;
    logic [TICKET_BITS-1:0]  ticket_reg, ticket_next;
    logic [31:0]             disp_reg, disp_next;
    lts_pkg::link_t          link_reg, link_next;

    logic                    in_use, is_ready, hit, wr_hit;
    logic [lts_pkg::SUM_W-1:0] tix_ext, acc_new;
    logic [31:0]             tix32;

    assign in_use   = CELL_ID < int'(ctx.n);
    assign is_ready = in_use && (state_reg == lts_pkg::ST_READY);
    assign hit      = in_use && (int'(ctx.idx) == CELL_ID);
    assign wr_hit   = wr_cmd.en && (int'(wr_cmd.idx) == CELL_ID);
    assign tix_ext  = {{(lts_pkg::SUM_W-TICKET_BITS){1'b0}}, ticket_reg};
    assign acc_new  = link_in.sum + tix_ext;
    assign tix32    = {8'b0, wr_cmd.ticket};

    always_comb begin
        link_next = link_in;
        if (link_in.valid) begin
            if (!link_in.pick) begin
                if (is_ready) begin
                    link_next.sum = acc_new;
                end
                if (in_use && state_reg == lts_pkg::ST_RUNNING) begin
                    link_next.running = 1'b1;
                end
                if (hit) begin
                    link_next.tgt_state = state_reg;
                    link_next.tgt_disp  = disp_reg;
                end
            end else if (is_ready && !link_in.found) begin
                link_next.sum = acc_new;
                if ({{(lts_pkg::SUM_W-28){1'b0}}, ctx.drawn} <= acc_new) begin
                    link_next.found  = 1'b1;
                    link_next.winner = 8'(CELL_ID);
                end
            end
        end
    end

    always_comb begin
        state_next  = state_reg;
        ticket_next = ticket_reg;
        disp_next   = disp_reg;
        if (wr_hit) begin
            unique case (wr_cmd.op)
                lts_pkg::MODE_LOAD: begin
                    ticket_next = tix32[TICKET_BITS-1:0];
                    disp_next   = '0;
                    state_next  = lts_pkg::ST_READY;
                end
                lts_pkg::MODE_DISPATCH: begin
                    state_next = lts_pkg::ST_RUNNING;
                    if (disp_reg != 32'hFFFF_FFFF) begin
                        disp_next = disp_reg + 32'd1;
                    end
                end
                lts_pkg::MODE_FINISH: begin
                    state_next = wr_cmd.to_fin ? lts_pkg::ST_FINISHED : lts_pkg::ST_READY;
                end
                default: begin
                    state_next = state_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lts_pkg::ST_FINISHED;
            link_reg  <= '0;
        end else begin
            state_reg <= state_next;
            link_reg  <= link_next;
        end
        ticket_reg <= ticket_next;
        disp_reg   <= disp_next;
    end

    assign link_out = link_reg;

endmodule

>>> hw/rtl/lts_mod.sv
// iterative remainder unit, one quotient bit a cycle
module lts_mod (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [27:0] divisor,
    output logic        done,
    output logic [27:0] remainder
);

    logic [27:0] rem_reg, rem_next;
    logic [31:0] shift_reg, shift_next;
    logic [27:0] div_reg, div_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [28:0] trial;

    assign trial = {rem_reg, shift_reg[31]};

    always_comb begin
        rem_next   = rem_reg;
        shift_next = shift_reg;
        div_next   = div_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start) begin
            rem_next   = '0;
            shift_next = dividend;
            div_next   = divisor;
            cnt_next   = '0;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            shift_next = {shift_reg[30:0], 1'b0};
            if (trial >= {1'b0, div_reg}) begin
                rem_next = 28'(trial - {1'b0, div_reg});
            end else begin
                rem_next = trial[27:0];
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg   <= rem_next;
        shift_reg <= shift_next;
        div_reg   <= div_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

>>> hw/rtl/lottery_task_scheduler.sv
// top level of the lottery task scheduler: controller, cell chain and remainder unit
//
//  channel   | direction | handshake          | payload
//  s_ (in)   | slave     | s_tvalid/s_tready  | s_tuser mode, s_tdata task fields
//  m_ (out)  | master    | m_tvalid/m_tready  | m_tuser status, m_tdata result fields
//  cfg       | write     | cfg_wr_en          | cfg_wr_data number of table entries in use
//
// load, dispatch and finish make one pass down the cell chain
// select makes a sum pass, runs the 32 step remainder unit, then makes a pick pass
// one item at a time; a new item is taken while the last result waits on m_tready
// reset (aresetn low, synchronous) marks every task finished and sets 16 entries in use
// a stalled result holds the controller in its emit state until m_tready
module lottery_task_scheduler #(
    parameter int MAX_TASKS   = 16,
    parameter int TICKET_BITS = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // task_index[3:0], ticket_count[27:4],
                                   // random_value[59:28], to_finished[60]
    input  logic [1:0]  s_tuser,   // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // winner slot[3:0], drawn ticket[31:4],
                                   // ready ticket sum[59:32], dispatch_total[91:60]
    output logic [1:0]  m_tuser,   // status[1:0]
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data
);

    // controller state
    lts_pkg::fsm_t    fsm_reg, fsm_next;
    lts_pkg::mode_t   mode_reg, mode_next;
    logic [3:0]       idx_reg, idx_next;
    logic [23:0]      ticket_reg, ticket_next;
    logic [31:0]      rnd_reg, rnd_next;
    logic             fin_reg, fin_next;
    logic [4:0]       slot_limit_reg;

    // result being assembled
    lts_pkg::status_t status_reg, status_next;
    logic [3:0]       winner_reg, winner_next;
    logic [27:0]      drawn_reg, drawn_next;
    logic [27:0]      active_reg, active_next;
    logic [31:0]      dtot_reg, dtot_next;

    // output register
    logic             m_tvalid_reg, m_tvalid_next;
    logic [95:0]      m_tdata_reg, m_tdata_next;
    logic [1:0]       m_tuser_reg, m_tuser_next;

    lts_pkg::link_t   inject_reg, inject_next;
    lts_pkg::link_t   link [MAX_TASKS+1];
    lts_pkg::link_t   tail;
    lts_pkg::ctx_t    ctx;
    lts_pkg::wr_cmd_t wr_cmd;

    logic [4:0]       n_eff;
    logic             idx_ok;
    logic             div_start, div_done;
    logic [27:0]      div_rem;
    logic             accept;

    // entries in use: the configured limit capped at the table depth
    assign n_eff  = (int'(slot_limit_reg) > MAX_TASKS) ? 5'(MAX_TASKS) : slot_limit_reg;
    assign idx_ok = {1'b0, idx_reg} < n_eff;

    assign s_tready = (fsm_reg == lts_pkg::FSM_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign ctx.n     = n_eff;
    assign ctx.idx   = idx_reg;
    assign ctx.drawn = drawn_reg;

    assign link[0] = inject_reg;
    assign tail    = link[MAX_TASKS];

    // one cell per task, the pass token ripples one cell a cycle
    for (genvar k = 0; k < MAX_TASKS; k++) begin : g_cell
        lts_cell #(
            .CELL_ID     (k),
            .TICKET_BITS (TICKET_BITS)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctx      (ctx),
            .wr_cmd   (wr_cmd),
            .link_in  (link[k]),
            .link_out (link[k+1])
        );
    end

    // ticket draw: random_value mod ready sum, divisor taken from the sum pass
    lts_mod u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (rnd_reg),
        .divisor   (tail.sum[27:0]),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_comb begin
        fsm_next      = fsm_reg;
        mode_next     = mode_reg;
        idx_next      = idx_reg;
        ticket_next   = ticket_reg;
        rnd_next      = rnd_reg;
        fin_next      = fin_reg;
        status_next   = status_reg;
        winner_next   = winner_reg;
        drawn_next    = drawn_reg;
        active_next   = active_reg;
        dtot_next     = dtot_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        inject_next   = '0;
        div_start     = 1'b0;
        wr_cmd        = '0;

        unique case (fsm_reg)
            lts_pkg::FSM_IDLE: begin
                if (accept) begin
                    mode_next   = lts_pkg::mode_t'(s_tuser);
                    idx_next    = s_tdata[3:0];
                    ticket_next = s_tdata[27:4];
                    rnd_next    = s_tdata[59:28];
                    fin_next    = s_tdata[60];
                    // sum pass collects ready sum, running flag and the addressed task
                    inject_next.valid     = 1'b1;
                    inject_next.tgt_state = lts_pkg::ST_FINISHED;
                    fsm_next              = lts_pkg::FSM_SCAN;
                end
            end
            lts_pkg::FSM_SCAN: begin
                if (tail.valid) begin
                    status_next = lts_pkg::STATUS_ILLEGAL;
                    winner_next = '0;
                    drawn_next  = '0;
                    active_next = '0;
                    dtot_next   = '0;
                    fsm_next    = lts_pkg::FSM_EMIT;
                    unique case (mode_reg)
                        lts_pkg::MODE_LOAD: begin
                            if (idx_ok) begin
                                status_next = lts_pkg::STATUS_OK;
                            end
                        end
                        lts_pkg::MODE_SELECT: begin
                            if (!tail.running) begin
                                if (tail.sum == '0) begin
                                    status_next = lts_pkg::STATUS_EMPTY;
                                end else if (tail.sum <= lts_pkg::SUM_LIMIT) begin
                                    active_next = tail.sum[27:0];
                                    div_start   = 1'b1;
                                    fsm_next    = lts_pkg::FSM_DIVIDE;
                                end
                            end
                        end
                        lts_pkg::MODE_DISPATCH: begin
                            if (idx_ok && tail.tgt_state == lts_pkg::ST_READY
                                    && !tail.running) begin
                                status_next = lts_pkg::STATUS_OK;
                                // saturating count, matching the cell update
                                dtot_next = (tail.tgt_disp == 32'hFFFF_FFFF)
                                          ? tail.tgt_disp : tail.tgt_disp + 32'd1;
                            end
                        end
                        lts_pkg::MODE_FINISH: begin
                            if (idx_ok && tail.tgt_state == lts_pkg::ST_RUNNING) begin
                                status_next = lts_pkg::STATUS_OK;
                            end
                        end
                        default: begin
                            status_next = lts_pkg::STATUS_ILLEGAL;
                        end
                    endcase
                end
            end
            lts_pkg::FSM_DIVIDE: begin
                if (div_done) begin
                    drawn_next        = div_rem + 28'd1;
                    inject_next.valid = 1'b1;
                    inject_next.pick  = 1'b1;
                    inject_next.tgt_state = lts_pkg::ST_FINISHED;
                    fsm_next          = lts_pkg::FSM_PICK;
                end
            end
            lts_pkg::FSM_PICK: begin
                if (tail.valid) begin
                    winner_next = tail.winner[3:0];
                    status_next = lts_pkg::STATUS_OK;
                    fsm_next    = lts_pkg::FSM_EMIT;
                end
            end
            lts_pkg::FSM_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = status_reg;
                    m_tdata_next  = {4'b0, dtot_reg, active_reg, drawn_reg, winner_reg};
                    // table update lands together with the result
                    wr_cmd.en     = (status_reg == lts_pkg::STATUS_OK)
                                 && (mode_reg != lts_pkg::MODE_SELECT);
                    wr_cmd.op     = mode_reg;
                    wr_cmd.idx    = idx_reg;
                    wr_cmd.ticket = ticket_reg;
                    wr_cmd.to_fin = fin_reg;
                    fsm_next      = lts_pkg::FSM_IDLE;
                end
            end
            default: begin
                fsm_next = lts_pkg::FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg        <= lts_pkg::FSM_IDLE;
            m_tvalid_reg   <= 1'b0;
            inject_reg     <= '0;
            slot_limit_reg <= 5'd16;
        end else begin
            fsm_reg      <= fsm_next;
            m_tvalid_reg <= m_tvalid_next;
            inject_reg   <= inject_next;
            if (cfg_wr_en) begin
                slot_limit_reg <= cfg_wr_data;
            end
        end
        mode_reg    <= mode_next;
        idx_reg     <= idx_next;
        ticket_reg  <= ticket_next;
        rnd_reg     <= rnd_next;
        fin_reg     <= fin_next;
        status_reg  <= status_next;
        winner_reg  <= winner_next;
        drawn_reg   <= drawn_next;
        active_reg  <= active_next;
        dtot_reg    <= dtot_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

>>> hw/rtl/lts_checker.sv
// port checker for the lottery task scheduler and its bind
`include "assert_macros.svh"

module lts_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic [1:0]  m_tuser
);

    logic        res_ok;
    logic [27:0] drawn_f, sum_f;

    assign res_ok  = (m_tuser == lts_pkg::STATUS_OK);
    assign drawn_f = m_tdata[31:4];
    assign sum_f   = m_tdata[59:32];

    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `ASSERT_IMPLY(a_status_code, aclk, aresetn, m_tvalid, m_tuser <= lts_pkg::STATUS_ILLEGAL)
    `ASSERT_IMPLY(a_fail_zero, aclk, aresetn, m_tvalid && !res_ok, m_tdata[91:0] == 92'd0)
    `ASSERT_IMPLY(a_draw_range, aclk, aresetn, m_tvalid && drawn_f != 28'd0, drawn_f <= sum_f)

endmodule

bind lottery_task_scheduler lts_checker u_lts_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> sim/lottery_task_scheduler_tb.sv
// testbench for the lottery task scheduler: random task traffic checked against a predictor
`timescale 1ns / 100ps

module lottery_task_scheduler_tb;

    localparam int NTASK = 16;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 2 * NTASK + 60;

    // one result of the scheduler, as carried on m_tuser / m_tdata
    typedef struct packed {
        lts_pkg::status_t status;
        logic [3:0]       winner;
        logic [27:0]      drawn;
        logic [27:0]      active;
        logic [31:0]      dispatches;
    } sched_result_t;

    // predictor of the task table plus the queue of results it still expects
    class sched_scoreboard;
        lts_pkg::task_state_t state_tbl [NTASK];
        logic [23:0]          ticket_tbl [NTASK];
        logic [31:0]          disp_tbl [NTASK];
        logic [4:0]           slot_limit;
        sched_result_t        pending [$];
        int                   errors;

        function new();
            for (int i = 0; i < NTASK; i++) begin
                state_tbl[i] = lts_pkg::ST_FINISHED;
                ticket_tbl[i] = '0;
                disp_tbl[i] = '0;
            end
            slot_limit = 5'd16;
            errors = 0;
        endfunction

        function int in_use();
            return (slot_limit < NTASK) ? int'(slot_limit) : NTASK;
        endfunction

        function bit any_running(int n);
            for (int i = 0; i < n; i++)
                if (state_tbl[i] == lts_pkg::ST_RUNNING) return 1'b1;
            return 1'b0;
        endfunction

        // note an accepted input item and queue its expected result
        function void note_item(lts_pkg::mode_t md, logic [3:0] idx, logic [23:0] tix,
                                logic [31:0] rnd, logic fin);
            sched_result_t r;
            int n;
            logic [39:0] sum;
            logic [39:0] acc;
            logic [39:0] dr;
            r = '0;
            r.status = lts_pkg::STATUS_ILLEGAL;
            n = in_use();
            case (md)
                lts_pkg::MODE_LOAD: begin
                    if (idx < n) begin
                        ticket_tbl[idx] = tix;
                        disp_tbl[idx] = '0;
                        state_tbl[idx] = lts_pkg::ST_READY;
                        r.status = lts_pkg::STATUS_OK;
                    end
                end
                lts_pkg::MODE_SELECT: begin
                    if (!any_running(n)) begin
                        sum = '0;
                        for (int i = 0; i < n; i++)
                            if (state_tbl[i] == lts_pkg::ST_READY) sum += ticket_tbl[i];
                        if (sum == 0) begin
                            r.status = lts_pkg::STATUS_EMPTY;
                        end else if (sum <= 40'h000FFFFFFF) begin
                            dr = ({8'd0, rnd} % sum) + 1;
                            acc = '0;
                            for (int i = 0; i < n; i++) begin
                                if (state_tbl[i] == lts_pkg::ST_READY) begin
                                    acc += ticket_tbl[i];
                                    if (dr <= acc) begin
                                        r.winner = i[3:0];
                                        break;
                                    end
                                end
                            end
                            r.drawn = dr[27:0];
                            r.active = sum[27:0];
                            r.status = lts_pkg::STATUS_OK;
                        end
                    end
                end
                lts_pkg::MODE_DISPATCH: begin
                    if (idx < n && state_tbl[idx] == lts_pkg::ST_READY && !any_running(n)) begin
                        state_tbl[idx] = lts_pkg::ST_RUNNING;
                        if (disp_tbl[idx] != 32'hFFFF_FFFF) disp_tbl[idx]++;
                        r.dispatches = disp_tbl[idx];
                        r.status = lts_pkg::STATUS_OK;
                    end
                end
                default: begin
                    if (idx < n && state_tbl[idx] == lts_pkg::ST_RUNNING) begin
                        state_tbl[idx] = fin ? lts_pkg::ST_FINISHED : lts_pkg::ST_READY;
                        r.status = lts_pkg::STATUS_OK;
                    end
                end
            endcase
            pending.push_back(r);
        endfunction

        // compare one accepted result with the oldest expectation
        function void check_result(sched_result_t got);
            sched_result_t want;
            if (pending.size() == 0) begin
                report("result with nothing expected", 0, 0);
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status) report("status", want.status, got.status);
            if (got.winner !== want.winner) report("winner slot", want.winner, got.winner);
            if (got.drawn !== want.drawn) report("drawn ticket", want.drawn, got.drawn);
            if (got.active !== want.active) report("ready sum", want.active, got.active);
            if (got.dispatches !== want.dispatches)
                report("dispatch_total", want.dispatches, got.dispatches);
        endfunction

        function void report(string what, logic [31:0] want, logic [31:0] got);
            errors++;
            $display("MISMATCH %s: expected %0h got %0h", what, want, got);
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_wr_en;
    logic [4:0]  cfg_wr_data;

    sched_scoreboard sb;
    int  watchdog;
    bit  timed_out;
    int  sent_items;
    int  got_results;
    int  stall_style;   // receiver stall pattern, changed per phase

    lottery_task_scheduler #(.MAX_TASKS(16), .TICKET_BITS(24)) DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    // 10 ns clock
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // result side: sample at the rising edge, check every accepted result
    always @(posedge aclk) begin
        sched_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = lts_pkg::status_t'(m_tuser);
            got.winner = m_tdata[3:0];
            got.drawn = m_tdata[31:4];
            got.active = m_tdata[59:32];
            got.dispatches = m_tdata[91:60];
            sb.check_result(got);
            got_results++;
        end
    end

    // receiver stalls: style 0 never, 1 random, 2 random runs of stall and flow
    always @(negedge aclk) begin
        case (stall_style)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= (($urandom_range(0, 15) < 4) || m_tready == 1'b0 &&
                                  $urandom_range(0, 7) == 0) ? ~m_tready : m_tready;
        endcase
    end

    // watchdog: cycles with no handshake on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            watchdog <= 0;
        end else begin
            watchdog <= watchdog + 1;
            if (watchdog >= WATCHDOG_LIMIT) begin
                $display("watchdog expired with %0d results pending", sb.pending.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // drive one item and wait for its acceptance
    task automatic send_item(lts_pkg::mode_t md, logic [3:0] idx, logic [23:0] tix,
                             logic [31:0] rnd, logic fin);
        s_tvalid <= 1'b1;
        s_tuser <= md;
        s_tdata <= {3'd0, fin, rnd, tix, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_item(md, idx, tix, rnd, fin);
        sent_items++;
        @(negedge aclk);
    endtask

    task automatic idle_gap(int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(negedge aclk);
    endtask

    // wait until every expected result has arrived, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_slot_limit(logic [4:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        sb.slot_limit = value;
    endtask

    // random ticket value: mostly small, sometimes at the extremes
    function automatic logic [23:0] pick_tickets();
        case ($urandom_range(0, 9))
            0: return 24'd0;
            1: return 24'hFFFFFF;
            2: return 24'($urandom());
            default: return 24'($urandom_range(1, 1000));
        endcase
    endfunction

    // one random item, biased toward legal scheduling sequences
    task automatic random_item();
        int n;
        int run_idx;
        lts_pkg::mode_t md;
        logic [3:0] idx;
        n = sb.in_use();
        run_idx = -1;
        for (int i = 0; i < n; i++)
            if (sb.state_tbl[i] == lts_pkg::ST_RUNNING) run_idx = i;
        idx = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 9) < 8 && n > 0) idx = 4'($urandom_range(0, n - 1));
        if ($urandom_range(0, 9) < 2) begin
            md = lts_pkg::mode_t'($urandom_range(0, 3));          // noise
        end else if (run_idx >= 0) begin
            md = lts_pkg::MODE_FINISH;
            idx = run_idx[3:0];
        end else begin
            case ($urandom_range(0, 5))
                0: md = lts_pkg::MODE_LOAD;
                1, 2: md = lts_pkg::MODE_SELECT;
                default: md = lts_pkg::MODE_DISPATCH;
            endcase
        end
        send_item(md, idx, pick_tickets(), $urandom(), $urandom_range(0, 3) == 0);
    endtask

    initial begin
        sched_scoreboard tmp;
        int burst;
        tmp = new();
        sb = tmp;
        watchdog = 0;
        sent_items = 0;
        got_results = 0;
        stall_style = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = lts_pkg::MODE_LOAD;
        m_tready = 1'b1;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 5'd16;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed: empty table, extremes, every mode and misuse
        send_item(lts_pkg::MODE_SELECT, 4'd0, 24'd0, 32'd5, 1'b0);          // nothing ready
        send_item(lts_pkg::MODE_DISPATCH, 4'd0, 24'd0, 32'd0, 1'b0);        // not ready
        send_item(lts_pkg::MODE_FINISH, 4'd3, 24'd0, 32'd0, 1'b1);          // not running
        send_item(lts_pkg::MODE_LOAD, 4'd0, 24'd0, 32'd0, 1'b0);
        send_item(lts_pkg::MODE_SELECT, 4'd0, 24'd0, 32'hFFFFFFFF, 1'b0);   // zero tickets
        send_item(lts_pkg::MODE_LOAD, 4'd15, 24'hFFFFFF, 32'd0, 1'b0);
        send_item(lts_pkg::MODE_LOAD, 4'd7, 24'd1, 32'd0, 1'b0);
        send_item(lts_pkg::MODE_SELECT, 4'd0, 24'd0, 32'hFFFFFFFF, 1'b0);
        send_item(lts_pkg::MODE_SELECT, 4'd0, 24'd0, 32'd0, 1'b0);
        send_item(lts_pkg::MODE_DISPATCH, 4'd7, 24'd0, 32'd0, 1'b0);
        send_item(lts_pkg::MODE_SELECT, 4'd0, 24'd0, 32'd1, 1'b0);    // select while running
        send_item(lts_pkg::MODE_DISPATCH, 4'd15, 24'd0, 32'd0, 1'b0); // dispatch while running
        send_item(lts_pkg::MODE_LOAD, 4'd7, 24'd9, 32'd0, 1'b1);      // load while running
        send_item(lts_pkg::MODE_DISPATCH, 4'd7, 24'd0, 32'd0, 1'b0);
        send_item(lts_pkg::MODE_FINISH, 4'd7, 24'd0, 32'd0, 1'b0);
        send_item(lts_pkg::MODE_DISPATCH, 4'd15, 24'd0, 32'd0, 1'b0);
        send_item(lts_pkg::MODE_FINISH, 4'd15, 24'd0, 32'd0, 1'b1);
        for (int i = 1; i < 16; i++)                                 // large sum, still under the limit
            send_item(lts_pkg::MODE_LOAD, i[3:0], 24'hFFFFFF, 32'd0, 1'b0);
        send_item(lts_pkg::MODE_SELECT, 4'd0, 24'd0, 32'hFFFFFFFF, 1'b0);
        drain();

        // out-of-range index with a short table
        write_slot_limit(5'd1);
        send_item(lts_pkg::MODE_LOAD, 4'd1, 24'd3, 32'd0, 1'b0);
        send_item(lts_pkg::MODE_LOAD, 4'd0, 24'd3, 32'd0, 1'b0);
        send_item(lts_pkg::MODE_SELECT, 4'd0, 24'd0, 32'd2, 1'b0);
        drain();

        // random phases across several table sizes and stall styles
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_slot_limit(5'd16);
                1: write_slot_limit(5'd2);
                2: write_slot_limit(5'($urandom_range(3, 15)));
                3: write_slot_limit(5'd31);
                4: write_slot_limit(5'd0);
                default: write_slot_limit(5'd16);
            endcase
            stall_style = ph % 3;
            for (int k = 0; k < 75; ) begin
                burst = $urandom_range(1, 12);
                for (int b = 0; b < burst && k < 75; b++, k++) random_item();
                if (k == 40) drain();                // pause until all results are in
                else if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 40));
            end
            drain();
        end

        $display("covered %0d items and %0d results over table sizes 0, 1, 2, 16, 31",
                 sent_items, got_results);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
